// File: hdl/dual_controller_text_column_renderer_unit_defines.svh
// Assertion helpers for the text column renderer.
`ifndef DUAL_CONTROLLER_TEXT_COLUMN_RENDERER_UNIT_DEFINES_SVH
`define DUAL_CONTROLLER_TEXT_COLUMN_RENDERER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DCTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define DCTR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dctr_pkg.sv
`default_nettype none

package dctr_pkg;

    // Input request kinds (s_axis_tuser)
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_SETPOS  = 2'd1;
    localparam logic [1:0] KIND_PRINT   = 2'd2;
    localparam logic [1:0] KIND_ENDLINE = 2'd3;

    // Display controller command bytes
    localparam logic [7:0] CMD_PAGE = 8'hB8;
    localparam logic [7:0] CMD_COL  = 8'h40;

    // Character code mapping
    localparam logic [15:0] CODE_WIDE_MAX = 16'h00FF;
    localparam logic [15:0] CODE_REMAP    = 16'h0390;
    localparam logic [7:0]  CODE_FIRST    = 8'h20;

    // Glyph width register
    localparam logic [3:0] GW_RESET = 4'd6;
    localparam logic [3:0] GW_MAX   = 4'd8;

    // Half boundary and column wrap
    localparam logic [7:0] COL_HALF = 8'd64;

    // Width of font address arithmetic (covers stores up to 4096 bytes)
    localparam int ADDR_CALC_W = 13;
    localparam int BASE_W      = 12;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_POS_PAGE = 4'b0010,
        ST_POS_COL  = 4'b0100,
        ST_DATA     = 4'b1000
    } seq_state_t;

    // One bus write on its way to the output register
    typedef struct packed {
        logic       valid;
        logic       is_data;
        logic       right_half;
        logic [7:0] bus_byte;
        logic       use_font;
        logic       last;
    } slot_t;

endpackage

`default_nettype wire

// File: hdl/dual_controller_text_column_renderer_unit.sv
`default_nettype none

// Text renderer for a 128x64 display made of two 64-column controllers. Each
// request on the slave stream is one of: load a font byte, set the cursor,
// print a character, or end the line (kind in s_axis_tuser). A printed
// character turns into display bus writes on the master stream: a blank
// column, then glyph_width font columns, with page/column command pairs at the
// start of a message, when the cursor crosses into the right half and when it
// wraps to the next page. s_axis_tlast marks the last character of a message;
// m_axis_tlast marks the final bus write caused by a request. Font bytes live
// in a FONT_BYTES x 8 synchronous RAM with no reset: glyphs must be loaded
// before they are printed. Load, set-position and end-line requests complete
// in the idle state; a print request is set up there and then written out by
// the write sequencer. One write leaves per cycle while the master side does
// not stall, set by the single write sequencer and the one RAM read port. A
// one-deep request buffer takes the next request while the current one is
// still being written out, and the output register holds a finished write
// while the master side stalls. glyph_width may only be written while idle.
module dual_controller_text_column_renderer_unit #(
    parameter int FONT_BYTES = 2048,
    parameter int PAGE_COUNT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Glyph width register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,

    // Requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] char_code, [18:16] page_value, [23:19] char_column,
    // [34:24] font_address, [42:35] font_byte, [47:43] zero
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,   // message_end
    input  wire logic [1:0]  s_axis_tuser,   // kind

    // Bus writes
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] is_data, [1] right_half, [9:2] bus_byte, [15:10] zero
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast    // last
);

    localparam int AW = $clog2(FONT_BYTES);
    localparam int CW = dctr_pkg::ADDR_CALC_W;
    localparam int BW = dctr_pkg::BASE_W;

    // ------------------------------------------------------------------
    // Glyph width register
    // ------------------------------------------------------------------
    logic [3:0] gw_reg;
    logic [3:0] w_used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= dctr_pkg::GW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gw_reg <= cfg_data;
        end
    end

    // zero acts as one, anything above eight as eight
    always_comb
    begin
        if (gw_reg == 4'd0)
        begin
            w_used = 4'd1;
        end
        else if (gw_reg > dctr_pkg::GW_MAX)
        begin
            w_used = dctr_pkg::GW_MAX;
        end
        else
        begin
            w_used = gw_reg;
        end
    end

    // ------------------------------------------------------------------
    // Request buffer
    // ------------------------------------------------------------------
    logic        ibuf_valid_reg;
    logic [1:0]  ibuf_kind_reg;
    logic [15:0] ibuf_code_reg;
    logic        ibuf_end_reg;
    logic [2:0]  ibuf_page_reg;
    logic [4:0]  ibuf_col_reg;
    logic [10:0] ibuf_fa_reg;
    logic [7:0]  ibuf_fb_reg;
    logic        ibuf_take;

    dctr_pkg::seq_state_t state_reg, state_next;

    // buffer frees in the same cycle the sequencer takes it
    assign s_axis_tready = !ibuf_valid_reg || (state_reg == dctr_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ibuf_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            ibuf_valid_reg <= 1'b1;
        end
        else if (ibuf_take)
        begin
            ibuf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ibuf_kind_reg <= s_axis_tuser;
            ibuf_code_reg <= s_axis_tdata[15:0];
            ibuf_end_reg  <= s_axis_tlast;
            ibuf_page_reg <= s_axis_tdata[18:16];
            ibuf_col_reg  <= s_axis_tdata[23:19];
            ibuf_fa_reg   <= s_axis_tdata[34:24];
            ibuf_fb_reg   <= s_axis_tdata[42:35];
        end
    end

    // ------------------------------------------------------------------
    // Cursor and sequencer state
    // ------------------------------------------------------------------
    logic [7:0]    page_reg, page_next;
    logic [7:0]    col_reg, col_next;
    logic          in_msg_reg, in_msg_next;
    logic          dropped_reg, dropped_next;
    logic [3:0]    k_reg, k_next;          // 0 = blank column, 1..w = font columns
    logic          end_reg, end_next;      // current char closes its message
    logic          ctrl_reg, ctrl_next;    // control code, font columns read as zero
    logic [BW-1:0] base_reg, base_next;    // font address of the glyph's first column
    logic          done_reg, done_next;    // pending position pair closes the char

    // character code mapping and glyph base
    logic [15:0]   code_sub;
    logic [7:0]    code_g;
    logic [7:0]    code_ofs;
    logic [BW-1:0] base_calc;

    assign code_sub  = ibuf_code_reg - dctr_pkg::CODE_REMAP;
    assign code_g    = (ibuf_code_reg > dctr_pkg::CODE_WIDE_MAX) ? code_sub[7:0]
                                                                 : ibuf_code_reg[7:0];
    assign code_ofs  = code_g - dctr_pkg::CODE_FIRST;
    assign base_calc = BW'(w_used) * BW'(code_ofs);

    // font RAM addressing
    logic [CW-1:0] wr_addr;
    logic [CW-1:0] rd_addr;
    logic          wr_in_range;
    logic          rd_in_range;
    logic          mem_we;
    logic          rd_en;

    assign wr_addr     = CW'(ibuf_fa_reg);
    assign rd_addr     = CW'(base_reg) + CW'(k_reg) - CW'(1);
    assign wr_in_range = wr_addr < CW'(FONT_BYTES);
    assign rd_in_range = rd_addr < CW'(FONT_BYTES);

    // position and column helpers
    logic       right_now;
    logic [7:0] col_inc;
    logic [7:0] page_inc;
    logic       final_col;
    logic       adv;

    // message start temporaries
    logic [7:0] st_page;
    logic [7:0] st_col;
    logic       st_drop;
    logic       st_start;

    dctr_pkg::slot_t slot;

    logic        out_valid_reg;
    logic        out_is_data_reg;
    logic        out_right_reg;
    logic [7:0]  out_byte_reg;
    logic        out_use_font_reg;
    logic        out_last_reg;
    logic [7:0]  rdata_reg;

    assign right_now = (col_reg >= dctr_pkg::COL_HALF);
    assign col_inc   = col_reg + 8'd1;
    assign page_inc  = page_reg + 8'd1;
    assign final_col = (k_reg == w_used);
    assign adv       = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        page_next    = page_reg;
        col_next     = col_reg;
        in_msg_next  = in_msg_reg;
        dropped_next = dropped_reg;
        k_next       = k_reg;
        end_next     = end_reg;
        ctrl_next    = ctrl_reg;
        base_next    = base_reg;
        done_next    = done_reg;
        ibuf_take    = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        st_page      = page_reg;
        st_col       = col_reg;
        st_drop      = dropped_reg;
        st_start     = !in_msg_reg;

        slot.valid      = 1'b0;
        slot.is_data    = 1'b0;
        slot.right_half = right_now;
        slot.bus_byte   = 8'd0;
        slot.use_font   = 1'b0;
        slot.last       = 1'b0;

        unique case (state_reg)
            dctr_pkg::ST_IDLE:
            begin
                if (ibuf_valid_reg)
                begin
                    ibuf_take = 1'b1;
                    case (ibuf_kind_reg)
                        dctr_pkg::KIND_LOAD:
                        begin
                            mem_we = wr_in_range;
                        end
                        dctr_pkg::KIND_SETPOS:
                        begin
                            page_next    = 8'(ibuf_page_reg);
                            col_next     = 8'(9'(ibuf_col_reg) * 9'(w_used));
                            in_msg_next  = 1'b0;
                            dropped_next = 1'b0;
                        end
                        dctr_pkg::KIND_ENDLINE:
                        begin
                            page_next    = page_inc;
                            col_next     = 8'd0;
                            in_msg_next  = 1'b0;
                            dropped_next = 1'b0;
                        end
                        default:
                        begin
                            // print: message start checks, then set up the char
                            if (st_start)
                            begin
                                st_drop = 1'b0;
                                if (st_page >= 8'(PAGE_COUNT))
                                begin
                                    st_page = 8'd0;
                                    st_drop = 1'b1;
                                end
                                else if (st_col[7])
                                begin
                                    st_col  = 8'd0;
                                    st_page = page_inc;
                                    if (st_page >= 8'(PAGE_COUNT))
                                    begin
                                        st_page = 8'd0;
                                        st_drop = 1'b1;
                                    end
                                end
                            end
                            page_next = st_page;
                            col_next  = st_col;
                            k_next    = 4'd0;
                            done_next = 1'b0;
                            end_next  = ibuf_end_reg;
                            ctrl_next = (code_g < dctr_pkg::CODE_FIRST);
                            base_next = base_calc;
                            if (st_drop)
                            begin
                                in_msg_next  = !ibuf_end_reg;
                                dropped_next = !ibuf_end_reg;
                            end
                            else
                            begin
                                in_msg_next  = 1'b1;
                                dropped_next = 1'b0;
                                state_next   = st_start ? dctr_pkg::ST_POS_PAGE
                                                        : dctr_pkg::ST_DATA;
                            end
                        end
                    endcase
                end
            end

            dctr_pkg::ST_POS_PAGE:
            begin
                slot.valid    = 1'b1;
                slot.bus_byte = page_reg | dctr_pkg::CMD_PAGE;
                if (adv)
                begin
                    state_next = dctr_pkg::ST_POS_COL;
                end
            end

            dctr_pkg::ST_POS_COL:
            begin
                slot.valid    = 1'b1;
                slot.bus_byte = dctr_pkg::CMD_COL | {2'b00, col_reg[5:0]};
                slot.last     = done_reg;
                if (adv)
                begin
                    state_next = done_reg ? dctr_pkg::ST_IDLE : dctr_pkg::ST_DATA;
                end
            end

            dctr_pkg::ST_DATA:
            begin
                slot.valid    = 1'b1;
                slot.is_data  = 1'b1;
                slot.use_font = (k_reg != 4'd0) && !ctrl_reg && rd_in_range;
                rd_en         = adv && (k_reg != 4'd0);
                if (end_reg && final_col)
                begin
                    // message end: column advances with no boundary handling
                    slot.last = 1'b1;
                    if (adv)
                    begin
                        col_next     = col_inc;
                        in_msg_next  = 1'b0;
                        dropped_next = 1'b0;
                        state_next   = dctr_pkg::ST_IDLE;
                    end
                end
                else if (col_inc == dctr_pkg::COL_HALF)
                begin
                    if (adv)
                    begin
                        col_next   = col_inc;
                        k_next     = k_reg + 4'd1;
                        done_next  = final_col;
                        state_next = dctr_pkg::ST_POS_PAGE;
                    end
                end
                else if (col_inc[7])
                begin
                    if (page_inc >= 8'(PAGE_COUNT))
                    begin
                        // ran off the last page: drop the rest of the message
                        slot.last = 1'b1;
                        if (adv)
                        begin
                            col_next     = 8'd0;
                            page_next    = 8'd0;
                            dropped_next = !end_reg;
                            in_msg_next  = !end_reg;
                            state_next   = dctr_pkg::ST_IDLE;
                        end
                    end
                    else if (adv)
                    begin
                        col_next   = 8'd0;
                        page_next  = page_inc;
                        k_next     = k_reg + 4'd1;
                        done_next  = final_col;
                        state_next = dctr_pkg::ST_POS_PAGE;
                    end
                end
                else if (final_col)
                begin
                    slot.last = 1'b1;
                    if (adv)
                    begin
                        col_next   = col_inc;
                        state_next = dctr_pkg::ST_IDLE;
                    end
                end
                else if (adv)
                begin
                    col_next = col_inc;
                    k_next   = k_reg + 4'd1;
                end
            end

            default:
            begin
                state_next = dctr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dctr_pkg::ST_IDLE;
            page_reg    <= 8'd0;
            col_reg     <= 8'd0;
            in_msg_reg  <= 1'b0;
            dropped_reg <= 1'b0;
            k_reg       <= 4'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            page_reg    <= page_next;
            col_reg     <= col_next;
            in_msg_reg  <= in_msg_next;
            dropped_reg <= dropped_next;
            k_reg       <= k_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg  <= end_next;
        ctrl_reg <= ctrl_next;
        base_reg <= base_next;
    end

    // ------------------------------------------------------------------
    // Font RAM: writes only from the idle state, reads only from the
    // data state, so the two ports never touch the same cycle.
    // Read data is held while the output register stalls.
    // ------------------------------------------------------------------
    logic [7:0] font_mem [FONT_BYTES];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[wr_addr[AW-1:0]] <= ibuf_fb_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= font_mem[rd_addr[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= slot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_is_data_reg  <= slot.is_data;
            out_right_reg    <= slot.right_half;
            out_byte_reg     <= slot.bus_byte;
            out_use_font_reg <= slot.use_font;
            out_last_reg     <= slot.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0,
                            (out_use_font_reg ? rdata_reg : out_byte_reg),
                            out_right_reg,
                            out_is_data_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "dual_controller_text_column_renderer_unit_defines.svh"

    `DCTR_ASSERT(a_take_only_idle, (ibuf_valid_reg && s_axis_tready) |-> (state_reg == dctr_pkg::ST_IDLE), "request buffer overwritten while busy")
    `DCTR_ASSERT(a_data_col_left, (state_reg == dctr_pkg::ST_DATA) |-> !col_reg[7], "data write past right edge")
    `DCTR_ASSERT(a_k_bound, (state_reg == dctr_pkg::ST_DATA) |-> (k_reg <= w_used), "glyph column index past glyph width")
    `DCTR_ASSERT_ALWAYS(a_no_out_in_reset, (!rst_n) |-> !m_axis_tvalid, "bus write during reset")

endmodule

`default_nettype wire
